FILE: hdl/crt_pkg.sv
package crt_pkg;

  localparam int MAX_COUNT   = 4;
  localparam int STORE_DEPTH = 4;
  localparam int IDX_W       = 2;
  localparam int CNT_W       = 3;
  localparam int MOD_W       = 16;
  localparam int SOL_W       = 64;
  localparam int PRD_W       = 2 * MOD_W;
  localparam int MUL_STEPS   = MOD_W;
  localparam int MUL_CNT_W   = 5;
  localparam int REM_LONG    = SOL_W;
  localparam int REM_SHORT   = PRD_W;
  localparam int REM_CNT_W   = 7;

  typedef struct packed {
    logic [MOD_W-1:0] modulus;
    logic [MOD_W-1:0] residue;
    logic             last;
  } in_word_t;

  typedef struct packed {
    logic [SOL_W-1:0] solution;
    logic             too_many;
  } out_word_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_PROD, S_PROD_W, S_ISEL, S_COF, S_COF_W, S_CRED_W,
    S_EXP, S_EXPA_W, S_EXP_SQ, S_EXPB_W, S_V_W, S_TERM, S_TERM_W,
    S_SUM_RED, S_RESULT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_START, OP_PROD_MUL, OP_PROD_WB, OP_COF_INIT, OP_COF_MUL,
    OP_COF_WB, OP_J_INC, OP_CRED, OP_EXP_INIT, OP_EXP_MA, OP_EXP_WA,
    OP_EXP_MB, OP_EXP_WB, OP_V_MUL, OP_V_WB, OP_TERM, OP_SUM_ADD,
    OP_SUM_RED, OP_NEXT_I, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   store;
  } dp_cmd_t;

  typedef struct packed {
    logic ovf;
    logic zero_mod;
    logic j_end;
    logic j_is_i;
    logic i_end;
    logic m_small;
    logic expo_zero;
    logic expo_bit0;
    logic mul_busy;
    logic rem_busy;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: hdl/crt_reconstruct.sv
// Chinese remainder reconstruction over up to MAX_COUNT prime moduli.
// Input channel (in_valid/in_ready/in_word): one word per congruence,
// modulus and residue, with last set on the word that closes the set.
// Words without last are stored, one a cycle, and give no result; words
// beyond MAX_COUNT are dropped and flag the set, which then closes with
// solution 0 and too_many set.
// Output channel (out_valid/out_ready/out_word): one word per closed set.
// After the closing word the block computes alone, in_ready low: products
// and cofactors go through a shift-add multiplier, every reduction modulo
// m_i through a one-bit-a-cycle remainder unit (the 64-bit cofactor, or a
// 32-bit product of two residues, as in the Fermat exponentiation).
// The result sits in an output register; while it waits, words of the next
// set, its closing word too, are still taken, but the new result is held
// until the old one leaves.
// Synchronous reset empties the set and drops any pending result.
module crt_reconstruct
  import crt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  crt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (in_word.last),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  crt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_word   (in_word),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

FILE: hdl/crt_mulu.sv
module crt_mulu
  import crt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SOL_W-1:0] a,
  input  logic [MOD_W-1:0] b,
  output logic             busy,
  output logic [SOL_W-1:0] prod
);

  logic [MUL_CNT_W-1:0] left;
  logic [SOL_W-1:0]     ma;
  logic [MOD_W-1:0]     mb;
  logic [SOL_W-1:0]     p;

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (start) begin
      left <= MUL_CNT_W'(MUL_STEPS);
    end else if (left != '0) begin
      left <= left - 1'b1;
    end
  end

  // shift-add, one multiplier bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      ma <= a;
      mb <= b;
      p  <= '0;
    end else if (left != '0) begin
      if (mb[0]) begin
        p <= p + ma;
      end
      ma <= ma << 1;
      mb <= mb >> 1;
    end
  end

  assign busy = (left != '0);
  assign prod = p;

endmodule

FILE: hdl/crt_remu.sv
module crt_remu
  import crt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             short_op,
  input  logic [SOL_W-1:0] x_in,
  input  logic [MOD_W-1:0] m,
  output logic             busy,
  output logic [MOD_W-1:0] rem
);

  logic [REM_CNT_W-1:0] left;
  logic [SOL_W-1:0]     x;
  logic [MOD_W-1:0]     r;
  logic [MOD_W:0]       t;
  logic [MOD_W:0]       t_sub;
  logic [MOD_W-1:0]     r_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (start) begin
      left <= short_op ? REM_CNT_W'(REM_SHORT) : REM_CNT_W'(REM_LONG);
    end else if (left != '0) begin
      left <= left - 1'b1;
    end
  end

  // restoring remainder; r stays below m so one compare-subtract per bit
  always_comb begin
    t      = {r, x[SOL_W-1]};
    t_sub  = t - {1'b0, m};
    r_next = (t >= {1'b0, m}) ? t_sub[MOD_W-1:0] : t[MOD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= short_op ? {x_in[PRD_W-1:0], {(SOL_W-PRD_W){1'b0}}} : x_in;
      r <= '0;
    end else if (left != '0) begin
      x <= x << 1;
      r <= r_next;
    end
  end

  assign busy = (left != '0);
  assign rem  = r;

endmodule

FILE: hdl/crt_dp.sv
module crt_dp
  import crt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  dp_cmd_t   cmd,
  input  in_word_t  in_word,
  output dp_stat_t  stat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic [MOD_W-1:0] mstore [STORE_DEPTH];
  logic [MOD_W-1:0] rstore [STORE_DEPTH];
  logic [CNT_W-1:0] cnt;
  logic             ovf;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] j;
  logic [SOL_W-1:0] prod;
  logic [SOL_W-1:0] cof;
  logic [SOL_W-1:0] sum;
  logic [SOL_W:0]   s65;
  logic [SOL_W:0]   s65_sub;
  logic [MOD_W-1:0] acc;
  logic [MOD_W-1:0] base;
  logic [MOD_W-1:0] expo;

  logic [MOD_W-1:0] m_i;
  logic [MOD_W-1:0] m_j;
  logic [MOD_W-1:0] r_i;
  logic             zero_mod;
  logic             mul_start;
  logic [SOL_W-1:0] mul_a;
  logic [MOD_W-1:0] mul_b;
  logic             mul_busy;
  logic [SOL_W-1:0] mul_p;
  logic             rem_start;
  logic             rem_short;
  logic [MOD_W-1:0] sm_a;
  logic [MOD_W-1:0] sm_b;
  logic [PRD_W-1:0] sm_p;
  logic [SOL_W-1:0] rem_x;
  logic             rem_busy;
  logic [MOD_W-1:0] rem_r;

  assign m_i = mstore[i[IDX_W-1:0]];
  assign m_j = mstore[j[IDX_W-1:0]];
  assign r_i = rstore[i[IDX_W-1:0]];

  always_comb begin
    zero_mod = 1'b0;
    for (int k = 0; k < STORE_DEPTH; k++) begin
      if (CNT_W'(k) < cnt && mstore[k] == '0) begin
        zero_mod = 1'b1;
      end
    end
  end

  assign mul_start = (cmd.op == OP_PROD_MUL) || (cmd.op == OP_COF_MUL) ||
                     (cmd.op == OP_TERM);
  assign mul_a     = (cmd.op == OP_PROD_MUL) ? prod : cof;
  assign mul_b     = (cmd.op == OP_TERM) ? acc : m_j;

  always_comb begin
    case (cmd.op)
      OP_EXP_MA: begin
        sm_a = acc;
        sm_b = base;
      end
      OP_EXP_MB: begin
        sm_a = base;
        sm_b = base;
      end
      default: begin
        sm_a = acc;
        sm_b = r_i;
      end
    endcase
  end

  assign sm_p      = sm_a * sm_b;
  assign rem_start = (cmd.op == OP_CRED) || (cmd.op == OP_EXP_MA) ||
                     (cmd.op == OP_EXP_MB) || (cmd.op == OP_V_MUL);
  assign rem_short = (cmd.op != OP_CRED);
  assign rem_x     = rem_short ? {{(SOL_W-PRD_W){1'b0}}, sm_p} : cof;

  crt_mulu u_mulu (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .prod  (mul_p)
  );

  crt_remu u_remu (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .short_op (rem_short),
    .x_in     (rem_x),
    .m        (m_i),
    .busy     (rem_busy),
    .rem      (rem_r)
  );

  assign s65_sub = s65 - {1'b0, prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      ovf       <= 1'b0;
      i         <= '0;
      j         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.store) begin
        if (cnt < CNT_W'(MAX_COUNT)) begin
          cnt <= cnt + 1'b1;
        end else begin
          ovf <= 1'b1;
        end
      end
      case (cmd.op)
        OP_START: begin
          i <= '0;
          j <= '0;
        end
        OP_COF_INIT:                 j <= '0;
        OP_PROD_WB, OP_COF_WB, OP_J_INC: j <= j + 1'b1;
        OP_SUM_RED, OP_NEXT_I:       i <= i + 1'b1;
        OP_OUT: begin
          cnt       <= '0;
          ovf       <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store && cnt < CNT_W'(MAX_COUNT)) begin
      mstore[cnt[IDX_W-1:0]] <= in_word.modulus;
      rstore[cnt[IDX_W-1:0]] <= in_word.residue;
    end
    case (cmd.op)
      OP_START: begin
        prod <= SOL_W'(1);
        sum  <= '0;
      end
      OP_PROD_WB:  prod <= mul_p;
      OP_COF_INIT: cof  <= SOL_W'(1);
      OP_COF_WB:   cof  <= mul_p;
      OP_EXP_INIT: begin
        base <= rem_r;
        acc  <= MOD_W'(1);
        expo <= m_i - MOD_W'(2);
      end
      OP_EXP_WA:   acc <= rem_r;
      OP_EXP_WB: begin
        base <= rem_r;
        expo <= expo >> 1;
      end
      OP_V_WB:     acc <= rem_r;
      OP_SUM_ADD:  s65 <= {1'b0, sum} + {1'b0, mul_p};
      OP_SUM_RED:  sum <= (s65 >= {1'b0, prod}) ? s65_sub[SOL_W-1:0] : s65[SOL_W-1:0];
      OP_OUT: begin
        out_word.solution <= (ovf || zero_mod) ? '0 : sum;
        out_word.too_many <= ovf;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.ovf       = ovf;
    stat.zero_mod  = zero_mod;
    stat.j_end     = (j == cnt);
    stat.j_is_i    = (j == i);
    stat.i_end     = (i == cnt);
    stat.m_small   = (m_i < MOD_W'(2));
    stat.expo_zero = (expo == '0);
    stat.expo_bit0 = expo[0];
    stat.mul_busy  = mul_busy;
    stat.rem_busy  = rem_busy;
    stat.out_free  = !out_valid || out_ready;
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_COUNT))
    else $error("entry count beyond limit");
  a_sum_reduced: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_SUM_RED |=> sum < prod)
    else $error("accumulator not reduced");
  a_mul_free: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_busy)
    else $error("multiplier restarted while busy");
  a_rem_free: assert property (@(posedge clk) disable iff (rst)
    rem_start |-> !rem_busy)
    else $error("remainder unit restarted while busy");
  a_set_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_OUT |=> cnt == '0 && !ovf && out_valid)
    else $error("set not cleared after result");
`endif

endmodule

FILE: hdl/crt_ctrl.sv
module crt_ctrl
  import crt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_last,
  input  dp_stat_t stat,
  output logic     in_ready,
  output dp_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (in_valid && in_last) state_next = S_CHECK;
      S_CHECK:   state_next = (stat.ovf || stat.zero_mod) ? S_RESULT : S_PROD;
      S_PROD:    state_next = stat.j_end ? S_ISEL : S_PROD_W;
      S_PROD_W:  if (!stat.mul_busy) state_next = S_PROD;
      S_ISEL: begin
        if (stat.i_end) begin
          state_next = S_RESULT;
        end else if (!stat.m_small) begin
          state_next = S_COF;
        end
      end
      S_COF: begin
        if (stat.j_end) begin
          state_next = S_CRED_W;
        end else if (!stat.j_is_i) begin
          state_next = S_COF_W;
        end
      end
      S_COF_W:   if (!stat.mul_busy) state_next = S_COF;
      S_CRED_W:  if (!stat.rem_busy) state_next = S_EXP;
      S_EXP: begin
        if (stat.expo_zero) begin
          state_next = S_V_W;
        end else if (stat.expo_bit0) begin
          state_next = S_EXPA_W;
        end else begin
          state_next = S_EXPB_W;
        end
      end
      S_EXPA_W:  if (!stat.rem_busy) state_next = S_EXP_SQ;
      S_EXP_SQ:  state_next = S_EXPB_W;
      S_EXPB_W:  if (!stat.rem_busy) state_next = S_EXP;
      S_V_W:     if (!stat.rem_busy) state_next = S_TERM;
      S_TERM:    state_next = S_TERM_W;
      S_TERM_W:  if (!stat.mul_busy) state_next = S_SUM_RED;
      S_SUM_RED: state_next = S_ISEL;
      S_RESULT:  if (stat.out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    cmd.store = (state == S_IDLE) && in_valid;
    cmd.op    = OP_NONE;
    case (state)
      S_CHECK:   if (!(stat.ovf || stat.zero_mod)) cmd.op = OP_START;
      S_PROD:    if (!stat.j_end) cmd.op = OP_PROD_MUL;
      S_PROD_W:  if (!stat.mul_busy) cmd.op = OP_PROD_WB;
      S_ISEL: begin
        if (!stat.i_end) begin
          cmd.op = stat.m_small ? OP_NEXT_I : OP_COF_INIT;
        end
      end
      S_COF: begin
        if (stat.j_end) begin
          cmd.op = OP_CRED;
        end else if (stat.j_is_i) begin
          cmd.op = OP_J_INC;
        end else begin
          cmd.op = OP_COF_MUL;
        end
      end
      S_COF_W:   if (!stat.mul_busy) cmd.op = OP_COF_WB;
      S_CRED_W:  if (!stat.rem_busy) cmd.op = OP_EXP_INIT;
      S_EXP: begin
        if (stat.expo_zero) begin
          cmd.op = OP_V_MUL;
        end else if (stat.expo_bit0) begin
          cmd.op = OP_EXP_MA;
        end else begin
          cmd.op = OP_EXP_MB;
        end
      end
      S_EXPA_W:  if (!stat.rem_busy) cmd.op = OP_EXP_WA;
      S_EXP_SQ:  cmd.op = OP_EXP_MB;
      S_EXPB_W:  if (!stat.rem_busy) cmd.op = OP_EXP_WB;
      S_V_W:     if (!stat.rem_busy) cmd.op = OP_V_WB;
      S_TERM:    cmd.op = OP_TERM;
      S_TERM_W:  if (!stat.mul_busy) cmd.op = OP_SUM_ADD;
      S_SUM_RED: cmd.op = OP_SUM_RED;
      S_RESULT:  if (stat.out_free) cmd.op = OP_OUT;
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule
